// File: design/tsc_pkg.sv
// shared types and constants of the two-stack calculator
`timescale 1ns / 1ps
`default_nettype none

package tsc_pkg;

    localparam int VALUE_DEPTH_DEF    = 20;
    localparam int OPERATOR_DEPTH_DEF = 16;

    localparam logic [7:0] CHAR_ADD = 8'h2B;
    localparam logic [7:0] CHAR_SUB = 8'h2D;
    localparam logic [7:0] CHAR_MUL = 8'h2A;
    localparam logic [7:0] CHAR_DIV = 8'h2F;

    localparam int DIV_W     = 48;
    localparam int DIV_STEPS = 48;
    localparam int DIV_CNT_W = 6;

    typedef enum logic [1:0] {
        MODE_PUSH_OP  = 2'd0,
        MODE_PUSH_VAL = 2'd1,
        MODE_EXEC     = 2'd2,
        MODE_NONE     = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_OP   = 3'd1,
        ST_VAL_FULL = 3'd2,
        ST_OP_FULL  = 3'd3,
        ST_FEW      = 3'd4,
        ST_DIV0     = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        RES_ZERO = 3'd0,
        RES_ADD  = 3'd1,
        RES_SUB  = 3'd2,
        RES_MUL  = 3'd3,
        RES_DIV  = 3'd4
    } t_res_sel;

    typedef struct packed {
        logic     load;
        logic     push_op;
        logic     push_val;
        logic     pop_first;
        logic     pop_second;
        logic     cap_next;
        logic     mul_start;
        logic     div_init;
        logic     div_step;
        logic     emit;
        logic     report;
        t_status  status;
        t_res_sel res_sel;
    } t_cmd;

    typedef struct packed {
        t_mode   mode;
        logic    op_bad;
        logic    op_full;
        logic    val_full;
        logic    few;
        t_opcode opc;
        logic    nxt_zero;
        logic    div_last;
    } t_stat;

endpackage

`default_nettype wire

// File: design/tsc_dp.sv
// datapath: item registers, both stacks, add/sub, multiplier, serial divider, result register
`timescale 1ns / 1ps
`default_nettype none

module tsc_dp #(
    parameter int VALUE_DEPTH    = tsc_pkg::VALUE_DEPTH_DEF,
    parameter int OPERATOR_DEPTH = tsc_pkg::OPERATOR_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tsc_pkg::t_cmd      i_cmd,
    output tsc_pkg::t_stat          o_stat,
    input  wire logic [1:0]         i_mode,
    input  wire logic [7:0]         i_operator_char,
    input  wire logic signed [31:0] i_value,
    output logic                    o_done,
    output logic [2:0]              o_status,
    output logic signed [31:0]      o_result,
    output logic signed [31:0]      o_top_operand,
    output logic signed [31:0]      o_next_operand,
    output logic [1:0]              o_operator_used
);
    import tsc_pkg::*;

    localparam int VAL_CW = $clog2(VALUE_DEPTH + 1);
    localparam int VAL_AW = $clog2(VALUE_DEPTH);
    localparam int OP_CW  = $clog2(OPERATOR_DEPTH + 1);
    localparam int OP_AW  = (OPERATOR_DEPTH > 1) ? $clog2(OPERATOR_DEPTH) : 1;

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    // item registers
    t_mode              r_mode;
    logic [7:0]         r_char;
    logic signed [31:0] r_val;

    // stacks
    logic [VAL_CW-1:0]  r_val_cnt;
    logic [OP_CW-1:0]   r_op_cnt;
    logic signed [31:0] r_val_mem [VALUE_DEPTH];
    t_opcode            r_op_mem [OPERATOR_DEPTH];
    logic signed [31:0] r_val_rd;
    t_opcode            r_op_rd;

    // operands
    logic signed [31:0] r_top;
    logic signed [31:0] r_nxt;
    t_opcode            r_opc;

    // multiplier and divider
    logic signed [63:0]   r_prod;
    logic [DIV_W-1:0]     r_quo;
    logic [31:0]          r_rem;
    logic [31:0]          r_dsr;
    logic                 r_neg;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    // result register
    logic               r_done;
    t_status            r_status;
    logic signed [31:0] r_result;
    logic signed [31:0] r_top_out;
    logic signed [31:0] r_nxt_out;
    t_opcode            r_opu;

    logic              op_ok;
    t_opcode           op_code;
    logic [VAL_CW-1:0] val_cnt_m1;
    logic [OP_CW-1:0]  op_cnt_m1;
    logic [VAL_AW-1:0] val_wa;
    logic [VAL_AW-1:0] val_ra;
    logic [OP_AW-1:0]  op_wa;
    logic [OP_AW-1:0]  op_ra;
    logic [31:0]       top_bits;
    logic [31:0]       nxt_bits;
    logic [31:0]       top_abs;
    logic [31:0]       nxt_abs;
    logic [32:0]       rem_sh;
    logic              rem_ge;
    logic [32:0]       rem_sub;
    logic [32:0]       sum33;
    logic [32:0]       dif33;
    logic [31:0]       add_res;
    logic [31:0]       sub_res;
    logic [31:0]       mul_res;
    logic [31:0]       div_res;
    logic              mul_ovf;
    logic [31:0]       res_mux;

    always_comb begin
        op_ok   = 1'b1;
        op_code = OP_ADD;
        priority if (r_char == CHAR_ADD) begin
            op_code = OP_ADD;
        end else if (r_char == CHAR_SUB) begin
            op_code = OP_SUB;
        end else if (r_char == CHAR_MUL) begin
            op_code = OP_MUL;
        end else if (r_char == CHAR_DIV) begin
            op_code = OP_DIV;
        end else begin
            op_ok = 1'b0;
        end
    end

    assign val_cnt_m1 = r_val_cnt - 1'b1;
    assign op_cnt_m1  = r_op_cnt - 1'b1;
    assign val_wa     = r_val_cnt[VAL_AW-1:0];
    assign val_ra     = val_cnt_m1[VAL_AW-1:0];
    assign op_wa      = r_op_cnt[OP_AW-1:0];
    assign op_ra      = op_cnt_m1[OP_AW-1:0];

    always_comb begin
        o_stat          = '0;
        o_stat.mode     = r_mode;
        o_stat.op_bad   = !op_ok;
        o_stat.op_full  = (r_op_cnt == OP_CW'(OPERATOR_DEPTH));
        o_stat.val_full = (r_val_cnt == VAL_CW'(VALUE_DEPTH));
        o_stat.few      = (r_op_cnt == '0) || (r_val_cnt < VAL_CW'(2));
        o_stat.opc      = r_opc;
        o_stat.nxt_zero = (r_nxt == '0);
        o_stat.div_last = (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= t_mode'(i_mode);
            r_char <= i_operator_char;
            r_val  <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_val) begin
            r_val_mem[val_wa] <= r_val;
        end
        if (i_cmd.pop_first || i_cmd.pop_second) begin
            r_val_rd <= r_val_mem[val_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_op) begin
            r_op_mem[op_wa] <= op_code;
        end
        if (i_cmd.pop_first) begin
            r_op_rd <= r_op_mem[op_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val_cnt <= '0;
            r_op_cnt  <= '0;
        end else begin
            if (i_cmd.push_val) begin
                r_val_cnt <= r_val_cnt + 1'b1;
            end else if (i_cmd.pop_first || i_cmd.pop_second) begin
                r_val_cnt <= val_cnt_m1;
            end
            if (i_cmd.push_op) begin
                r_op_cnt <= r_op_cnt + 1'b1;
            end else if (i_cmd.pop_first) begin
                r_op_cnt <= op_cnt_m1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop_second) begin
            r_top <= r_val_rd;
            r_opc <= r_op_rd;
        end
        if (i_cmd.cap_next) begin
            r_nxt <= r_val_rd;
        end
        if (i_cmd.mul_start) begin
            r_prod <= r_top * r_nxt;
        end
    end

    // magnitude restoring divider, one quotient bit a beat
    assign top_bits = r_top;
    assign nxt_bits = r_nxt;
    assign top_abs  = top_bits[31] ? (~top_bits + 32'd1) : top_bits;
    assign nxt_abs  = nxt_bits[31] ? (~nxt_bits + 32'd1) : nxt_bits;
    assign rem_sh   = {r_rem, r_quo[DIV_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, r_dsr});
    assign rem_sub  = rem_sh - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_quo     <= {top_abs, 16'h0000};
            r_dsr     <= nxt_abs;
            r_rem     <= '0;
            r_neg     <= top_bits[31] ^ nxt_bits[31];
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem     <= rem_ge ? rem_sub[31:0] : rem_sh[31:0];
            r_quo     <= {r_quo[DIV_W-2:0], rem_ge};
            r_div_cnt <= r_div_cnt + 1'b1;
        end
    end

    always_comb begin
        sum33   = {top_bits[31], top_bits} + {nxt_bits[31], nxt_bits};
        dif33   = {top_bits[31], top_bits} - {nxt_bits[31], nxt_bits};
        add_res = (sum33[32] != sum33[31]) ? (sum33[32] ? Q_MIN : Q_MAX) : sum33[31:0];
        sub_res = (dif33[32] != dif33[31]) ? (dif33[32] ? Q_MIN : Q_MAX) : dif33[31:0];
        mul_ovf = !((&r_prod[63:47]) || !(|r_prod[63:47]));
        mul_res = mul_ovf ? (r_prod[63] ? Q_MIN : Q_MAX) : r_prod[47:16];
        if (r_neg) begin
            div_res = ((|r_quo[DIV_W-1:32]) || (r_quo[31] && (|r_quo[30:0])))
                    ? Q_MIN : (~r_quo[31:0] + 32'd1);
        end else begin
            div_res = (|r_quo[DIV_W-1:31]) ? Q_MAX : r_quo[31:0];
        end
        unique case (i_cmd.res_sel)
            RES_ADD: res_mux = add_res;
            RES_SUB: res_mux = sub_res;
            RES_MUL: res_mux = mul_res;
            RES_DIV: res_mux = div_res;
            default: res_mux = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_status  <= i_cmd.status;
            r_result  <= res_mux;
            r_top_out <= i_cmd.report ? r_top : '0;
            r_nxt_out <= i_cmd.report ? r_nxt : '0;
            r_opu     <= i_cmd.report ? r_opc : OP_ADD;
        end
    end

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_result        = r_result;
    assign o_top_operand   = r_top_out;
    assign o_next_operand  = r_nxt_out;
    assign o_operator_used = r_opu;

    a_val_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_val_cnt <= VAL_CW'(VALUE_DEPTH))
        else $error("value count past depth");

    a_op_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_op_cnt <= OP_CW'(OPERATOR_DEPTH))
        else $error("operator count past depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.push_val && o_stat.val_full) && !(i_cmd.push_op && o_stat.op_full))
        else $error("push into full stack");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop_first |=> (r_op_cnt == OP_CW'($past(r_op_cnt) - 1'b1)))
        else $error("operator pop did not decrement");

endmodule

`default_nettype wire

// File: design/tsc_ctrl.sv
// controller state machine sequencing decode, pops and the arithmetic units
`timescale 1ns / 1ps
`default_nettype none

module tsc_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    output logic                o_busy,
    input  wire tsc_pkg::t_stat i_stat,
    output tsc_pkg::t_cmd       o_cmd
);
    import tsc_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_POP1  = 8'b0000_0100,
        S_POP2  = 8'b0000_1000,
        S_EXEC  = 8'b0001_0000,
        S_MUL   = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_DFIN  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state    = S_IDLE;
                o_cmd.emit = 1'b1;
                unique case (i_stat.mode)
                    MODE_PUSH_OP: begin
                        priority if (i_stat.op_bad) begin
                            o_cmd.status = ST_BAD_OP;
                        end else if (i_stat.op_full) begin
                            o_cmd.status = ST_OP_FULL;
                        end else begin
                            o_cmd.push_op = 1'b1;
                        end
                    end
                    MODE_PUSH_VAL: begin
                        if (i_stat.val_full) begin
                            o_cmd.status = ST_VAL_FULL;
                        end else begin
                            o_cmd.push_val = 1'b1;
                        end
                    end
                    MODE_EXEC: begin
                        if (i_stat.few) begin
                            o_cmd.status = ST_FEW;
                        end else begin
                            o_cmd.emit      = 1'b0;
                            o_cmd.pop_first = 1'b1;
                            n_state         = S_POP1;
                        end
                    end
                    default: begin
                        o_cmd.status = ST_OK;
                    end
                endcase
            end
            S_POP1: begin
                o_cmd.pop_second = 1'b1;
                n_state          = S_POP2;
            end
            S_POP2: begin
                o_cmd.cap_next = 1'b1;
                n_state        = S_EXEC;
            end
            S_EXEC: begin
                unique case (i_stat.opc)
                    OP_ADD: begin
                        o_cmd.emit    = 1'b1;
                        o_cmd.report  = 1'b1;
                        o_cmd.res_sel = RES_ADD;
                        n_state       = S_IDLE;
                    end
                    OP_SUB: begin
                        o_cmd.emit    = 1'b1;
                        o_cmd.report  = 1'b1;
                        o_cmd.res_sel = RES_SUB;
                        n_state       = S_IDLE;
                    end
                    OP_MUL: begin
                        o_cmd.mul_start = 1'b1;
                        n_state         = S_MUL;
                    end
                    default: begin
                        if (i_stat.nxt_zero) begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.report = 1'b1;
                            o_cmd.status = ST_DIV0;
                            n_state      = S_IDLE;
                        end else begin
                            o_cmd.div_init = 1'b1;
                            n_state        = S_DIV;
                        end
                    end
                endcase
            end
            S_MUL: begin
                o_cmd.emit    = 1'b1;
                o_cmd.report  = 1'b1;
                o_cmd.res_sel = RES_MUL;
                n_state       = S_IDLE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_DFIN;
                end
            end
            S_DFIN: begin
                o_cmd.emit    = 1'b1;
                o_cmd.report  = 1'b1;
                o_cmd.res_sel = RES_DIV;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// File: design/two_stack_calculator.sv
// top level of the two-stack Q16.16 calculator
//
// usage: drive i_mode, i_operator_char and i_value and raise start; the beat
// is taken at a rising edge with start high and busy low. mode 0 pushes an
// operator (+ - * /), mode 1 pushes a value, mode 2 pops one operator and two
// values and computes top op next with saturation, mode 3 does nothing.
// every beat gives exactly one result beat: o_done is high for one cycle
// with o_status, o_result, o_top_operand, o_next_operand, o_operator_used.
// a push or a rejected beat is decided in the check state; add, sub and divide
// by zero pop through both pop states to the exec state, mul adds the mul state,
// and divide runs the 48-step radix-2 divider, one quotient bit a cycle, then
// its finish state. one beat is worked on at a time; busy is low while
// the result shows, so the next beat can be taken at the edge that takes it.
// the result is not held: the receiver must take it in its one cycle.
// reset clears both stack counts and the controller; stack contents are not
// cleared and are only read after being pushed.
`timescale 1ns / 1ps
`default_nettype none

module two_stack_calculator #(
    parameter int VALUE_DEPTH    = tsc_pkg::VALUE_DEPTH_DEF,
    parameter int OPERATOR_DEPTH = tsc_pkg::OPERATOR_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_mode,
    input  wire logic [7:0]         i_operator_char,
    input  wire logic signed [31:0] i_value,
    output logic                    o_done,
    output logic [2:0]              o_status,
    output logic signed [31:0]      o_result,
    output logic signed [31:0]      o_top_operand,
    output logic signed [31:0]      o_next_operand,
    output logic [1:0]              o_operator_used
);
    import tsc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    tsc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    tsc_dp #(
        .VALUE_DEPTH    (VALUE_DEPTH),
        .OPERATOR_DEPTH (OPERATOR_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_mode          (i_mode),
        .i_operator_char (i_operator_char),
        .i_value         (i_value),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_result        (o_result),
        .o_top_operand   (o_top_operand),
        .o_next_operand  (o_next_operand),
        .o_operator_used (o_operator_used)
    );

endmodule

`default_nettype wire

// File: tb/two_stack_calculator_checker.sv
// checker of the two-stack calculator: predicts every result beat and compares it
`timescale 1ns / 1ps

module two_stack_calculator_checker #(
    parameter int VALUE_DEPTH    = tsc_pkg::VALUE_DEPTH_DEF,
    parameter int OPERATOR_DEPTH = tsc_pkg::OPERATOR_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [1:0]         i_mode,
    input  logic [7:0]         i_operator_char,
    input  logic signed [31:0] i_value,
    input  logic               i_done,
    input  logic [2:0]         i_status,
    input  logic signed [31:0] i_result,
    input  logic signed [31:0] i_top_operand,
    input  logic signed [31:0] i_next_operand,
    input  logic [1:0]         i_operator_used,
    output int                 o_errors,
    output int                 o_owed
);
    import tsc_pkg::*;

    typedef struct {
        t_status            status;
        logic signed [31:0] result;
        logic signed [31:0] top_operand;
        logic signed [31:0] next_operand;
        t_opcode            operator_used;
    } t_calc_beat;

    t_calc_beat         owed_results [$];
    t_opcode            operator_stack [OPERATOR_DEPTH];
    logic signed [31:0] value_stack [VALUE_DEPTH];
    int                 operator_count = 0;
    int                 value_count    = 0;
    int                 error_total    = 0;
    int                 owed_count     = 0;

    assign o_errors = error_total;
    assign o_owed   = owed_count;

    function automatic logic signed [31:0] clamp32(input longint x);
        if (x > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end
        if (x < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    function automatic t_calc_beat evaluate_beat(input t_mode mode, input logic [7:0] ch,
                                                 input logic signed [31:0] val);
        t_calc_beat r;
        t_opcode    code;
        logic       known;
        longint     top_val;
        longint     next_val;
        r.status        = ST_OK;
        r.result        = '0;
        r.top_operand   = '0;
        r.next_operand  = '0;
        r.operator_used = OP_ADD;
        case (mode)
            MODE_PUSH_OP: begin
                known = 1'b1;
                case (ch)
                    CHAR_ADD: code = OP_ADD;
                    CHAR_SUB: code = OP_SUB;
                    CHAR_MUL: code = OP_MUL;
                    CHAR_DIV: code = OP_DIV;
                    default: begin
                        code  = OP_ADD;
                        known = 1'b0;
                    end
                endcase
                if (!known) begin
                    r.status = ST_BAD_OP;
                end else if (operator_count >= OPERATOR_DEPTH) begin
                    r.status = ST_OP_FULL;
                end else begin
                    operator_stack[operator_count] = code;
                    operator_count++;
                end
            end
            MODE_PUSH_VAL: begin
                if (value_count >= VALUE_DEPTH) begin
                    r.status = ST_VAL_FULL;
                end else begin
                    value_stack[value_count] = val;
                    value_count++;
                end
            end
            MODE_EXEC: begin
                if (operator_count < 1 || value_count < 2) begin
                    r.status = ST_FEW;
                end else begin
                    operator_count--;
                    r.operator_used = operator_stack[operator_count];
                    value_count--;
                    top_val = value_stack[value_count];
                    value_count--;
                    next_val = value_stack[value_count];
                    r.top_operand  = top_val[31:0];
                    r.next_operand = next_val[31:0];
                    case (r.operator_used)
                        OP_ADD: r.result = clamp32(top_val + next_val);
                        OP_SUB: r.result = clamp32(top_val - next_val);
                        OP_MUL: r.result = clamp32((top_val * next_val) >>> 16);
                        default: begin
                            if (next_val == 0) begin
                                r.status = ST_DIV0;
                            end else begin
                                r.result = clamp32((top_val * 65536) / next_val);
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_total++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_calc_beat want;
        if (!i_rst_n) begin
            operator_count = 0;
            value_count    = 0;
            owed_results.delete();
        end else begin
            if (i_done) begin
                if (owed_results.size() == 0) begin
                    $error("result beat with no item outstanding");
                    error_total++;
                end else begin
                    want = owed_results.pop_front();
                    check_field("status", want.status, i_status);
                    check_field("result", want.result, i_result);
                    check_field("top_operand", want.top_operand, i_top_operand);
                    check_field("next_operand", want.next_operand, i_next_operand);
                    check_field("operator_used", want.operator_used, i_operator_used);
                end
            end
            if (i_start && !i_busy) begin
                owed_results.push_back(evaluate_beat(t_mode'(i_mode), i_operator_char,
                                                     i_value));
            end
        end
        owed_count = owed_results.size();
    end

endmodule

// File: tb/two_stack_calculator_test.sv
// top of the two-stack calculator test: stimulus, reset, clock and verdict
`timescale 1ns / 1ps

module two_stack_calculator_test;
    import tsc_pkg::*;

    localparam int PHASE_ITEMS = 110;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_mode;
    logic [7:0]         i_operator_char;
    logic signed [31:0] i_value;
    logic               o_done;
    logic [2:0]         o_status;
    logic signed [31:0] o_result;
    logic signed [31:0] o_top_operand;
    logic signed [31:0] o_next_operand;
    logic [1:0]         o_operator_used;

    int mismatches;
    int results_owed;
    int items_sent;
    int sender_idle_pct;

    two_stack_calculator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_operator_char (i_operator_char),
        .i_value         (i_value),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_result        (o_result),
        .o_top_operand   (o_top_operand),
        .o_next_operand  (o_next_operand),
        .o_operator_used (o_operator_used)
    );

    two_stack_calculator_checker calc_monitor (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_mode          (i_mode),
        .i_operator_char (i_operator_char),
        .i_value         (i_value),
        .i_done          (o_done),
        .i_status        (o_status),
        .i_result        (o_result),
        .i_top_operand   (o_top_operand),
        .i_next_operand  (o_next_operand),
        .i_operator_used (o_operator_used),
        .o_errors        (mismatches),
        .o_owed          (results_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic signed [31:0] pick_operand();
        logic signed [31:0] near;
        near = $urandom_range(32'h000FFFFF);
        case ($urandom_range(9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return '0;
            3, 4: return $urandom;
            default: return near - 32'sh00080000;
        endcase
    endfunction

    function automatic logic [7:0] pick_operator_char();
        case ($urandom_range(3))
            0: return CHAR_ADD;
            1: return CHAR_SUB;
            2: return CHAR_MUL;
            default: return CHAR_DIV;
        endcase
    endfunction

    task automatic send_beat(input t_mode mode, input logic [7:0] ch,
                             input logic signed [31:0] val);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start           <= 1'b1;
        i_mode          <= mode;
        i_operator_char <= ch;
        i_value         <= val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (mode != MODE_NONE) begin
            items_sent++;
        end
    endtask

    task automatic flood_stack(input bit values);
        int n;
        n = (values ? VALUE_DEPTH_DEF : OPERATOR_DEPTH_DEF) + $urandom_range(1, 4);
        repeat (n) begin
            if (values) begin
                send_beat(MODE_PUSH_VAL, 8'($urandom_range(255)), pick_operand());
            end else begin
                send_beat(MODE_PUSH_OP, pick_operator_char(), $urandom);
            end
        end
    endtask

    task automatic drain_stacks(input int rounds);
        repeat (rounds) begin
            send_beat(MODE_PUSH_VAL, 8'($urandom_range(255)), pick_operand());
            send_beat(MODE_PUSH_VAL, 8'($urandom_range(255)), pick_operand());
            send_beat(MODE_EXEC, 8'($urandom_range(255)), $urandom);
        end
    endtask

    task automatic run_sequence();
        int kind;
        int pairs;
        kind = $urandom_range(99);
        if (kind < 68) begin
            pairs = $urandom_range(1, 3);
            repeat (2 * pairs) begin
                send_beat(MODE_PUSH_VAL, 8'($urandom_range(255)), pick_operand());
            end
            repeat (pairs) send_beat(MODE_PUSH_OP, pick_operator_char(), $urandom);
            repeat (pairs) send_beat(MODE_EXEC, 8'($urandom_range(255)), $urandom);
        end else if (kind < 73) begin
            flood_stack(1'b1);
        end else if (kind < 78) begin
            flood_stack(1'b0);
        end else if (kind < 85) begin
            drain_stacks($urandom_range(4, 12));
        end else begin
            repeat ($urandom_range(1, 6)) begin
                send_beat(t_mode'($urandom_range(3)), 8'($urandom_range(255)), $urandom);
            end
        end
    endtask

    initial begin : stimulus
        int phase;
        int target;
        int guard;
        start           <= 1'b0;
        i_mode          <= MODE_PUSH_OP;
        i_operator_char <= '0;
        i_value         <= '0;
        i_rst_n         <= 1'b0;
        items_sent      = 0;
        sender_idle_pct = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty stacks, rejected characters, ignored mode
        send_beat(MODE_EXEC, 8'h00, 32'sh0);
        send_beat(MODE_PUSH_OP, 8'h00, 32'sh0);
        send_beat(MODE_PUSH_OP, 8'hFF, 32'shFFFFFFFF);
        send_beat(MODE_NONE, 8'hFF, 32'shFFFFFFFF);
        // saturating add, sub and mul
        send_beat(MODE_PUSH_VAL, 8'h00, 32'sh7FFFFFFF);
        send_beat(MODE_PUSH_VAL, 8'h00, 32'sh7FFFFFFF);
        send_beat(MODE_PUSH_OP, CHAR_ADD, 32'sh0);
        send_beat(MODE_EXEC, 8'h00, 32'sh0);
        send_beat(MODE_PUSH_VAL, 8'h00, 32'sh80000000);
        send_beat(MODE_PUSH_VAL, 8'h00, 32'sh7FFFFFFF);
        send_beat(MODE_PUSH_OP, CHAR_SUB, 32'sh0);
        send_beat(MODE_EXEC, 8'h00, 32'sh0);
        send_beat(MODE_PUSH_VAL, 8'h00, 32'sh7FFFFFFF);
        send_beat(MODE_PUSH_VAL, 8'h00, 32'sh80000000);
        send_beat(MODE_PUSH_OP, CHAR_MUL, 32'sh0);
        send_beat(MODE_EXEC, 8'h00, 32'sh0);
        // divide by zero, then a divide that overflows
        send_beat(MODE_PUSH_VAL, 8'h00, 32'sh0);
        send_beat(MODE_PUSH_VAL, 8'h00, 32'sh00010000);
        send_beat(MODE_PUSH_OP, CHAR_DIV, 32'sh0);
        send_beat(MODE_EXEC, 8'h00, 32'sh0);
        send_beat(MODE_PUSH_VAL, 8'h00, 32'shFFFFFFFF);
        send_beat(MODE_PUSH_VAL, 8'h00, 32'sh80000000);
        send_beat(MODE_PUSH_OP, CHAR_DIV, 32'sh0);
        send_beat(MODE_EXEC, 8'h00, 32'sh0);
        // operator present but only one value
        send_beat(MODE_PUSH_OP, CHAR_ADD, 32'sh0);
        send_beat(MODE_PUSH_VAL, 8'h00, 32'sh00000001);
        send_beat(MODE_EXEC, 8'h00, 32'sh0);

        // full stacks first, then mostly well-formed sequences
        flood_stack(1'b1);
        flood_stack(1'b0);
        drain_stacks(12);
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                1: sender_idle_pct = 53;
                3: sender_idle_pct = 18;
                default: sender_idle_pct = 0;
            endcase
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) run_sequence();
        end
        start <= 1'b0;

        guard = 0;
        while (results_owed != 0 && guard < 1000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (60) @(posedge i_clk);
        if (results_owed != 0) begin
            $error("%0d results never arrived", results_owed);
        end
        if (mismatches == 0 && results_owed == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
